// File: hw/rtl/picu_pkg.sv
// ----------------------------------------------------------------------------
// picu_pkg
// shared constants, operation codes and control types of the interrupt
// controller
// ----------------------------------------------------------------------------
`default_nettype none

package picu_pkg;

   // sizing
   localparam int SOURCE_COUNT  = 31;
   localparam int CONTEXT_COUNT = 4;
   localparam int PRIO_BITS     = 3;

   // fixed field widths
   localparam int FUNC_W  = 3;
   localparam int CTX_W   = 2;
   localparam int SRC_W   = 5;
   localparam int VALUE_W = 32;
   localparam int LINE_W  = 4;

   // source slots covered by the id field, slot zero reserved
   localparam int SRC_SLOTS  = 2 ** SRC_W;
   localparam int LINE_CTX   = (CONTEXT_COUNT < LINE_W) ? CONTEXT_COUNT : LINE_W;

   // priority scan: a group of lanes per cycle
   localparam int SCAN_LANES = 8;
   localparam int SCAN_STEPS = SRC_SLOTS / SCAN_LANES;
   localparam int LANE_W     = $clog2(SCAN_LANES);
   localparam int SCAN_IDX_W = $clog2(SCAN_STEPS);

   // enable bits that may be set: sources 1 to SOURCE_COUNT only
   localparam logic [VALUE_W-1:0] ENABLE_MASK =
      ((SOURCE_COUNT >= VALUE_W - 1) ? {VALUE_W{1'b1}} :
       ((VALUE_W'(1) << (SOURCE_COUNT + 1)) - VALUE_W'(1))) & ~VALUE_W'(1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LEVEL    = 3'd0,
      FUNC_CLAIM    = 3'd1,
      FUNC_COMPLETE = 3'd2,
      FUNC_PRIO     = 3'd3,
      FUNC_ENABLE   = 3'd4,
      FUNC_THRESH   = 3'd5
   } func_type;

   typedef struct packed {
      logic                  capture;
      logic                  scan;
      logic [SCAN_IDX_W-1:0] scan_idx;
      logic                  apply;
      logic                  finish;
   } cmd_type;

   typedef struct packed {
      logic req_is_claim;
   } stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/picu_ctrl.sv
// ----------------------------------------------------------------------------
// picu_ctrl
// sequencer: accept, optional priority scan, state update, result load
// ----------------------------------------------------------------------------
`default_nettype none

module picu_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire picu_pkg::stat_type stat,
   output picu_pkg::cmd_type       cmd
);
   import picu_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_APPLY  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [SCAN_IDX_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.scan_idx = scan_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               scan_cnt_in = '0;
               state_in    = stat.req_is_claim ? ST_SCAN : ST_APPLY;
            end
         end
         ST_SCAN: begin
            cmd.scan    = 1'b1;
            scan_cnt_in = scan_cnt_ff + SCAN_IDX_W'(1);
            if (scan_cnt_ff == SCAN_IDX_W'(SCAN_STEPS - 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/picu_datapath.sv
// ----------------------------------------------------------------------------
// picu_datapath
// source and context state, lane scan for the claim winner, line compute
// ----------------------------------------------------------------------------
`default_nettype none

module picu_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire picu_pkg::cmd_type              cmd,
   output picu_pkg::stat_type                  stat,
   input  wire logic [picu_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [picu_pkg::CTX_W-1:0]     req_context_id,
   input  wire logic [picu_pkg::SRC_W-1:0]     req_source_id,
   input  wire logic                           req_level,
   input  wire logic [picu_pkg::VALUE_W-1:0]   req_write_value,
   output logic      [picu_pkg::LINE_W-1:0]    rsp_irq_lines,
   output logic      [picu_pkg::SRC_W-1:0]     rsp_claimed_id
);
   import picu_pkg::*;

   // captured word
   logic [FUNC_W-1:0]  func_ff;
   logic [CTX_W-1:0]   ctx_ff;
   logic [SRC_W-1:0]   src_ff;
   logic               lvl_ff;
   logic [VALUE_W-1:0] val_ff;

   // controller state
   logic [SRC_SLOTS-1:0]                     pending_ff;
   logic [SRC_SLOTS-1:0]                     gateway_ff;
   logic [SRC_SLOTS-1:0][PRIO_BITS-1:0]      prio_ff;
   logic [CONTEXT_COUNT-1:0][VALUE_W-1:0]    en_ff;
   logic [CONTEXT_COUNT-1:0][PRIO_BITS-1:0]  thr_ff;

   // scan running best
   logic [SRC_W-1:0]     best_ff, best_in;
   logic [PRIO_BITS-1:0] top_ff, top_in;

   logic [LINE_W-1:0] lines;
   logic [SRC_W-1:0]  rsp_claimed_id_ff;
   logic [LINE_W-1:0] rsp_irq_lines_ff;
   logic              src_ok;
   logic              ctx_ok;

   assign stat.req_is_claim = (req_func == FUNC_CLAIM);
   assign src_ok = (src_ff != '0) && (int'(src_ff) <= SOURCE_COUNT);
   assign ctx_ok = (int'(ctx_ff) < CONTEXT_COUNT);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         ctx_ff  <= req_context_id;
         src_ff  <= req_source_id;
         lvl_ff  <= req_level;
         val_ff  <= req_write_value;
      end
   end

   // one group of lanes per cycle, strict compare keeps the lowest id on ties
   always_comb begin
      logic [SRC_W-1:0] sidx;
      best_in = best_ff;
      top_in  = top_ff;
      for (int l = 0; l < SCAN_LANES; l++) begin
         sidx = {cmd.scan_idx, LANE_W'(l)};
         if (ctx_ok && pending_ff[sidx] && en_ff[ctx_ff][sidx] &&
             (prio_ff[sidx] > thr_ff[ctx_ff]) && (prio_ff[sidx] > top_in)) begin
            top_in  = prio_ff[sidx];
            best_in = sidx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         best_ff <= '0;
         top_ff  <= '0;
      end else if (cmd.scan) begin
         best_ff <= best_in;
         top_ff  <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         gateway_ff <= '1;
         prio_ff    <= '0;
         en_ff      <= '0;
         thr_ff     <= '0;
      end else if (cmd.apply) begin
         case (func_ff)
            FUNC_LEVEL: begin
               if (src_ok && lvl_ff && gateway_ff[src_ff]) begin
                  pending_ff[src_ff] <= 1'b1;
                  gateway_ff[src_ff] <= 1'b0;
               end
            end
            FUNC_CLAIM: begin
               if (ctx_ok && best_ff != '0) begin
                  pending_ff[best_ff] <= 1'b0;
               end
            end
            FUNC_COMPLETE: begin
               if (ctx_ok && src_ok && en_ff[ctx_ff][src_ff]) begin
                  gateway_ff[src_ff] <= 1'b1;
               end
            end
            FUNC_PRIO: begin
               if (src_ok) begin
                  prio_ff[src_ff] <= val_ff[PRIO_BITS-1:0];
               end
            end
            FUNC_ENABLE: begin
               if (ctx_ok) begin
                  en_ff[ctx_ff] <= val_ff & ENABLE_MASK;
               end
            end
            FUNC_THRESH: begin
               if (ctx_ok) begin
                  thr_ff[ctx_ff] <= val_ff[PRIO_BITS-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // line per context: any pending enabled source above threshold
   always_comb begin
      lines = '0;
      for (int c = 0; c < LINE_CTX; c++) begin
         for (int s = 1; s <= SOURCE_COUNT; s++) begin
            if (pending_ff[s] && en_ff[c][s] && (prio_ff[s] > thr_ff[c])) begin
               lines[c] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_irq_lines_ff  <= lines;
         rsp_claimed_id_ff <= (func_ff == FUNC_CLAIM) ? best_ff : '0;
      end
   end

   assign rsp_irq_lines  = rsp_irq_lines_ff;
   assign rsp_claimed_id = rsp_claimed_id_ff;

endmodule

`default_nettype wire

// File: hw/rtl/platform_interrupt_controller_unit.sv
// ----------------------------------------------------------------------------
// platform_interrupt_controller_unit
// platform interrupt controller: gateways, pending bits, priorities,
// per-context enables and thresholds, claim and completion
// ----------------------------------------------------------------------------
// sequence: level, completion and register-write words pass through the apply
//    and finish states to rsp_valid; a claim first scans the 32 source slots
//    in groups of 8, then applies and finishes; a new word is accepted only
//    in idle, after the previous one is loaded into the result register
// reset: synchronous; clears pending bits, priorities, enables, thresholds,
//    opens every gateway and clears rsp_valid; the result register is not reset
`default_nettype none

module platform_interrupt_controller_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request words
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [picu_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [picu_pkg::CTX_W-1:0]     req_context_id,
   input  wire logic [picu_pkg::SRC_W-1:0]     req_source_id,
   input  wire logic                           req_level,
   input  wire logic [picu_pkg::VALUE_W-1:0]   req_write_value,
   // response words
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [picu_pkg::LINE_W-1:0]    rsp_irq_lines,
   output logic      [picu_pkg::SRC_W-1:0]     rsp_claimed_id
);
   import picu_pkg::*;

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: owns the handshakes and the scan count
   picu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: state registers, claim scan, line compute, result register
   picu_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_context_id  (req_context_id),
      .req_source_id   (req_source_id),
      .req_level       (req_level),
      .req_write_value (req_write_value),
      .rsp_irq_lines   (rsp_irq_lines),
      .rsp_claimed_id  (rsp_claimed_id)
   );

endmodule

`default_nettype wire

// File: bench/tb_platform_interrupt_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_platform_interrupt_controller_unit
// drives request words into the interrupt controller and checks every
// response word against a cycle-free model of gateways, pending bits,
// priorities, enables and thresholds; a directed opening is followed by
// weighted random traffic with random stalls on both channels
// ----------------------------------------------------------------------------

module tb_platform_interrupt_controller_unit;

   import picu_pkg::*;

   // func codes with no operation behind them
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   // one request word as seen on the req_ ports
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [CTX_W-1:0]   ctx;
      logic [SRC_W-1:0]   src;
      logic               lvl;
      logic [VALUE_W-1:0] val;
   } request_word_type;

   // one response word as seen on the rsp_ ports
   typedef struct packed {
      logic [LINE_W-1:0] lines;
      logic [SRC_W-1:0]  id;
   } irq_result_type;

   // a claim that went through, kept so that random traffic can complete it
   typedef struct packed {
      logic [CTX_W-1:0] ctx;
      logic [SRC_W-1:0] src;
   } claim_type;

   // model of the controller plus the queue of awaited response words
   class irq_scoreboard;
      logic [SRC_SLOTS-1:0] pending;
      logic [SRC_SLOTS-1:0] gate_open;
      logic [PRIO_BITS-1:0] prio [SRC_SLOTS];
      logic [VALUE_W-1:0]   enables [CONTEXT_COUNT];
      logic [PRIO_BITS-1:0] thresh [CONTEXT_COUNT];
      logic [VALUE_W-1:0]   enable_bits;
      irq_result_type       awaited [$];
      claim_type            completable [$];
      int                   errors;

      function new();
         pending   = '0;
         gate_open = '1;
         foreach (prio[i]) prio[i] = '0;
         foreach (enables[i]) enables[i] = '0;
         foreach (thresh[i]) thresh[i] = '0;
         // only real sources may be enabled, bit zero is reserved
         enable_bits = '0;
         for (int s = 1; s <= SOURCE_COUNT && s < VALUE_W; s++) enable_bits[s] = 1'b1;
         errors = 0;
      endfunction

      // highest priority above threshold, lowest id on a tie, zero if none
      function logic [SRC_W-1:0] winner(int c);
         logic [SRC_W-1:0]     best;
         logic [PRIO_BITS-1:0] top;
         best = '0;
         top  = '0;
         for (int s = 1; s <= SOURCE_COUNT; s++) begin
            if (pending[s] && enables[c][s] && prio[s] > thresh[c] && prio[s] > top) begin
               top  = prio[s];
               best = SRC_W'(s);
            end
         end
         return best;
      endfunction

      function void note_request(request_word_type w);
         irq_result_type   r;
         claim_type        cl;
         logic [SRC_W-1:0] got;
         bit               src_ok;
         bit               ctx_ok;
         src_ok = (w.src != '0) && (int'(w.src) <= SOURCE_COUNT);
         ctx_ok = int'(w.ctx) < CONTEXT_COUNT;
         got    = '0;
         case (w.func)
            FUNC_LEVEL: begin
               if (src_ok && w.lvl && gate_open[w.src]) begin
                  pending[w.src]   = 1'b1;
                  gate_open[w.src] = 1'b0;
               end
            end
            FUNC_CLAIM: begin
               if (ctx_ok) begin
                  got = winner(int'(w.ctx));
                  if (got != '0) begin
                     pending[got] = 1'b0;
                     cl.ctx = w.ctx;
                     cl.src = got;
                     completable.push_back(cl);
                     if (completable.size() > 32) void'(completable.pop_front());
                  end
               end
            end
            FUNC_COMPLETE: begin
               if (ctx_ok && src_ok && enables[w.ctx][w.src]) gate_open[w.src] = 1'b1;
            end
            FUNC_PRIO: begin
               if (src_ok) prio[w.src] = w.val[PRIO_BITS-1:0];
            end
            FUNC_ENABLE: begin
               if (ctx_ok) enables[w.ctx] = w.val & enable_bits;
            end
            FUNC_THRESH: begin
               if (ctx_ok) thresh[w.ctx] = w.val[PRIO_BITS-1:0];
            end
            default: ;
         endcase
         r.lines = '0;
         for (int c = 0; c < CONTEXT_COUNT && c < LINE_W; c++) begin
            if (winner(c) != '0) r.lines[c] = 1'b1;
         end
         r.id = got;
         awaited.push_back(r);
      endfunction

      function void check_response(logic [LINE_W-1:0] lines, logic [SRC_W-1:0] id);
         irq_result_type e;
         if (awaited.size() == 0) begin
            $error("response word with nothing awaited: irq_lines %h claimed_id %0d",
                   lines, id);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (lines !== e.lines) begin
            $error("irq_lines: expected %h, got %h", e.lines, lines);
            errors++;
         end
         if (id !== e.id) begin
            $error("claimed_id: expected %0d, got %0d", e.id, id);
            errors++;
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [FUNC_W-1:0]    req_func;
   logic [CTX_W-1:0]     req_context_id;
   logic [SRC_W-1:0]     req_source_id;
   logic                 req_level;
   logic [VALUE_W-1:0]   req_write_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [LINE_W-1:0]    rsp_irq_lines;
   logic [SRC_W-1:0]     rsp_claimed_id;

   irq_scoreboard sb;

   // when set, neither side inserts gaps or stalls
   bit steady;

   platform_interrupt_controller_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_context_id  (req_context_id),
      .req_source_id   (req_source_id),
      .req_level       (req_level),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_irq_lines   (rsp_irq_lines),
      .rsp_claimed_id  (rsp_claimed_id)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("tb_platform_interrupt_controller_unit: errors");
      $finish;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // present one word, hold it until taken, then note it in the model
   task automatic send_word(input request_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= w.func;
      req_context_id  <= w.ctx;
      req_source_id   <= w.src;
      req_level       <= w.lvl;
      req_write_value <= w.val;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
   endtask

   task automatic send(input logic [FUNC_W-1:0] f, input logic [CTX_W-1:0] c,
                       input logic [SRC_W-1:0] s, input logic l,
                       input logic [VALUE_W-1:0] v);
      request_word_type w;
      w.func = f;
      w.ctx  = c;
      w.src  = s;
      w.lvl  = l;
      w.val  = v;
      send_word(w);
   endtask

   // drop valid and wait for every awaited response word
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // weighted random word; completions mostly target earlier claims
   function automatic request_word_type random_word();
      request_word_type w;
      claim_type        cl;
      int               r;
      int               k;
      // every field gets random content first, so unused bits toggle too
      w.func = FUNC_W'($urandom_range(0, 7));
      w.ctx  = CTX_W'($urandom_range(0, 3));
      w.src  = SRC_W'($urandom_range(0, 31));
      w.lvl  = 1'($urandom_range(0, 1));
      w.val  = $urandom();
      r = $urandom_range(0, 99);
      if (r < 32) begin
         w.func = FUNC_LEVEL;
         w.src  = ($urandom_range(0, 9) == 0) ? '0 : SRC_W'($urandom_range(1, SOURCE_COUNT));
         w.lvl  = ($urandom_range(0, 6) != 0);
      end else if (r < 57) begin
         w.func = FUNC_CLAIM;
      end else if (r < 75) begin
         w.func = FUNC_COMPLETE;
         if (sb.completable.size() != 0 && $urandom_range(0, 3) != 0) begin
            k  = $urandom_range(0, sb.completable.size() - 1);
            cl = sb.completable[k];
            sb.completable.delete(k);
            w.ctx = cl.ctx;
            w.src = cl.src;
         end
      end else if (r < 84) begin
         w.func = FUNC_PRIO;
         if ($urandom_range(0, 1) == 0) w.val = VALUE_W'($urandom_range(1, 7));
      end else if (r < 91) begin
         w.func = FUNC_ENABLE;
         if ($urandom_range(0, 3) == 0) w.val = '1;
      end else if (r < 96) begin
         w.func = FUNC_THRESH;
         if ($urandom_range(0, 9) < 7) w.val = VALUE_W'($urandom_range(0, 2));
      end else begin
         w.func = ($urandom_range(0, 1) == 0) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
      end
      return w;
   endfunction

   // response side: check every taken word, stall at random
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_irq_lines, rsp_claimed_id);
         if (reset || steady) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ready <= 1'b1;
            end else begin
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   // stimulus
   initial begin
      sb     = new();
      steady = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= '0;
      req_context_id  <= '0;
      req_source_id   <= '0;
      req_level       <= 1'b0;
      req_write_value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send(FUNC_CLAIM,    2'd0, 5'd0,  1'b0, 32'h0);          // claim with nothing pending
      send(FUNC_LEVEL,    2'd0, 5'd5,  1'b1, 32'h0);          // pending but priority zero
      send(FUNC_PRIO,     2'd0, 5'd5,  1'b0, 32'hFFFF_FFFD);  // wide value keeps low bits
      send(FUNC_ENABLE,   2'd0, 5'd0,  1'b0, 32'hFFFF_FFFF);  // bit zero must not stick
      send(FUNC_LEVEL,    2'd0, 5'd0,  1'b1, 32'h0);          // reserved source
      send(FUNC_PRIO,     2'd0, 5'd0,  1'b0, 32'h7);          // reserved source
      send(FUNC_LEVEL,    2'd0, 5'd31, 1'b1, 32'h0);          // top source
      send(FUNC_PRIO,     2'd0, 5'd31, 1'b0, 32'h5);          // tie with source 5
      send(FUNC_LEVEL,    2'd0, 5'd9,  1'b0, 32'h0);          // low level does nothing
      send(FUNC_LEVEL,    2'd0, 5'd5,  1'b1, 32'h0);          // gateway already closed
      send(FUNC_THRESH,   2'd1, 5'd0,  1'b0, 32'hFFFF_FFF8);  // wide threshold masks to zero
      send(FUNC_ENABLE,   2'd1, 5'd0,  1'b0, 32'h8000_0001);
      send(FUNC_THRESH,   2'd0, 5'd0,  1'b0, 32'h5);          // equal to priority, no line
      send(FUNC_CLAIM,    2'd0, 5'd0,  1'b0, 32'h0);          // threshold blocks the claim
      send(FUNC_THRESH,   2'd0, 5'd0,  1'b0, 32'h4);
      send(FUNC_SPARE_LO, 2'd3, 5'd31, 1'b1, 32'hFFFF_FFFF);
      send(FUNC_SPARE_HI, 2'd3, 5'd31, 1'b1, 32'hFFFF_FFFF);
      send(FUNC_CLAIM,    2'd0, 5'd0,  1'b0, 32'h0);          // lowest id wins the tie
      send(FUNC_COMPLETE, 2'd2, 5'd5,  1'b0, 32'h0);          // not enabled there, ignored
      send(FUNC_LEVEL,    2'd0, 5'd5,  1'b1, 32'h0);          // still closed
      send(FUNC_COMPLETE, 2'd0, 5'd0,  1'b0, 32'h0);          // reserved id
      send(FUNC_COMPLETE, 2'd0, 5'd5,  1'b0, 32'h0);          // reopens the gateway
      send(FUNC_LEVEL,    2'd0, 5'd5,  1'b1, 32'h0);
      send(FUNC_CLAIM,    2'd1, 5'd0,  1'b0, 32'h0);          // only source 31 enabled
      send(FUNC_PRIO,     2'd0, 5'd5,  1'b0, 32'h7);          // max priority vs max threshold
      send(FUNC_THRESH,   2'd3, 5'd0,  1'b0, 32'h7);
      send(FUNC_CLAIM,    2'd3, 5'd0,  1'b0, 32'h0);

      // hold off until every response word is back
      drain();

      // random traffic in segments, one of them without any idling
      for (int seg = 0; seg < 7; seg++) begin
         steady = (seg == 2);
         repeat (100) send_word(random_word());
         if (seg == 4) drain();
      end
      steady = 1'b0;

      drain();
      // room for a stray response word to show up
      repeat (16) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_platform_interrupt_controller_unit: clean");
      else
         $display("tb_platform_interrupt_controller_unit: errors");
      $finish;
   end

endmodule

// File: platform_interrupt_controller_unit.f
hw/rtl/picu_pkg.sv
hw/rtl/picu_ctrl.sv
hw/rtl/picu_datapath.sv
hw/rtl/platform_interrupt_controller_unit.sv
bench/tb_platform_interrupt_controller_unit.sv
